@@ hw/rtl/cpu_time_line_parser_top_macros.svh @@
// Assertion macros shared by the CPU time line parser modules.
`ifndef CPU_TIME_LINE_PARSER_TOP_MACROS_SVH
`define CPU_TIME_LINE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CTLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ctlp_pkg.sv @@
// Shared types, constants and helpers of the CPU time line parser.
package ctlp_pkg;

  localparam int unsigned MAX_CPUS = 64;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned CPU_W    = 6;
  localparam logic [CNT_W-1:0] MAX_CPUS_V = CNT_W'(MAX_CPUS);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_CPUS);

  localparam int unsigned NFIELDS = 10;
  localparam int unsigned FLD_W   = 4;
  localparam logic [FLD_W-1:0] NFIELDS_V = FLD_W'(NFIELDS);

  localparam int unsigned IQ_DEPTH = 4;
  localparam int unsigned IQ_AW    = 2;
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = 3;

  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_C   = 8'h63;
  localparam logic [7:0] CH_P   = 8'h70;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_X   = 8'h78;

  localparam logic KIND_CPU = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef enum logic [1:0] {FC_BUSY, FC_IDLE, FC_GUEST, FC_NONE} fclass_t;

  // Which accumulator a field number lands in.
  function automatic fclass_t field_class(input logic [FLD_W-1:0] f);
    fclass_t c;
    if (f inside {4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd7}) begin
      c = FC_BUSY;
    end else if (f inside {4'd3, 4'd4}) begin
      c = FC_IDLE;
    end else if (f inside {4'd8, 4'd9}) begin
      c = FC_GUEST;
    end else begin
      c = FC_NONE;
    end
    return c;
  endfunction

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic             record_kind;
    logic [CPU_W-1:0] cpu_number;
    logic [63:0]      busy_ticks;
    logic [63:0]      idle_ticks;
    logic [CNT_W-1:0] cpu_total;
    logic [63:0]      switch_total;
    logic             switch_seen;
    logic             final_result;
  } out_word_t;

  // Classified input byte.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       eob;
    logic       is_digit;
    logic       is_blank;
    logic       is_nl;
    logic [3:0] digit;
  } cls_word_t;

  typedef struct packed {
    logic      valid;
    cls_word_t word;
  } iq_head_t;

  // Parser output: what to emit, with the last field commit still pending.
  typedef struct packed {
    logic             rec;
    logic             sum;
    logic [CPU_W-1:0] idx;
    logic [63:0]      busy;
    logic [63:0]      idle;
    logic [63:0]      guest;
    logic [63:0]      cm_num;
    fclass_t          cm_cls;
    logic [CNT_W-1:0] count;
    logic [63:0]      sw;
    logic             seen;
  } fin_req_t;

  typedef struct packed {
    logic             rec;
    logic             sum;
    logic [CPU_W-1:0] idx;
    logic [63:0]      busy;
    logic [63:0]      idle;
    logic [63:0]      guest;
    logic [CNT_W-1:0] count;
    logic [63:0]      sw;
    logic             seen;
  } fin_sum_t;

endpackage

@@ hw/rtl/ctlp_front.sv @@
// Front end: accepts bytes, classifies them and queues them for the parser.
module ctlp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctlp_pkg::in_word_t in_data,
  input  logic               pop_i,
  output ctlp_pkg::iq_head_t head_o
);

  ctlp_pkg::cls_word_t q_r [ctlp_pkg::IQ_DEPTH];
  logic [ctlp_pkg::IQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ctlp_pkg::IQ_AW:0]   cnt_r, cnt_nxt;
  ctlp_pkg::cls_word_t cls_c;
  logic [7:0] dig_sub;
  logic push;
  logic pop;

  always_comb begin
    dig_sub         = in_data.text_byte - ctlp_pkg::CH_0;
    cls_c.text_byte = in_data.text_byte;
    cls_c.eob       = in_data.end_of_buffer;
    cls_c.is_digit  = (in_data.text_byte >= ctlp_pkg::CH_0) &&
                      (in_data.text_byte <= ctlp_pkg::CH_9);
    cls_c.is_blank  = (in_data.text_byte == ctlp_pkg::CH_SP) ||
                      (in_data.text_byte == ctlp_pkg::CH_TAB);
    cls_c.is_nl     = (in_data.text_byte == ctlp_pkg::CH_NL);
    cls_c.digit     = dig_sub[3:0];
  end

  assign in_ready = (cnt_r != (ctlp_pkg::IQ_AW+1)'(ctlp_pkg::IQ_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = pop_i && (cnt_r != '0);

  assign head_o.valid = (cnt_r != '0);
  assign head_o.word  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + ctlp_pkg::IQ_AW'(push);
    rp_nxt  = rp_r + ctlp_pkg::IQ_AW'(pop);
    cnt_nxt = cnt_r + (ctlp_pkg::IQ_AW+1)'(push) - (ctlp_pkg::IQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls_c;
    end
  end

endmodule

@@ hw/rtl/ctlp_back.sv @@
// Parser back end: line state machine, field accumulation and record decisions.
`include "cpu_time_line_parser_top_macros.svh"

module ctlp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ctlp_pkg::CNT_W-1:0]     cpu_limit_i,
  input  ctlp_pkg::iq_head_t             head_i,
  input  logic                           room_i,
  output logic                           pop_o,
  output ctlp_pkg::fin_req_t             req_o
);

  typedef enum logic [3:0] {
    PH_START, PH_C, PH_CP, PH_CPU, PH_INDEX, PH_FWS, PH_FDIG, PH_FROZEN,
    PH_CT, PH_CTX, PH_CTXT, PH_SWWS, PH_SWDIG, PH_SKIP
  } phase_t;

  function automatic logic in_cpu(input phase_t ph);
    return (ph == PH_INDEX) || (ph == PH_FWS) || (ph == PH_FDIG) || (ph == PH_FROZEN);
  endfunction

  phase_t phase_r, phase_nxt, phase_tk;
  logic [2:0]                    len_r, len_nxt, len_inc;
  logic [ctlp_pkg::FLD_W-1:0]    fld_r, fld_nxt, fld_tk;
  logic [63:0]                   num_r, num_nxt, num_tk, num10;
  logic [ctlp_pkg::CNT_W-1:0]    idx_r, idx_nxt, idx_tk, idx_p1;
  logic [63:0]                   busy_r, busy_nxt, busy_tk;
  logic [63:0]                   idle_r, idle_nxt, idle_tk;
  logic [63:0]                   guest_r, guest_nxt, guest_tk;
  logic [ctlp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, cnt_fin;
  logic [63:0]                   sw_r, sw_nxt, sw_tk, sw10;
  logic                          swf_r, swf_nxt, swf_tk;
  logic [9:0]                    idx_ext, idx10;
  logic [ctlp_pkg::CNT_W-1:0]    idx_sat, lim;
  ctlp_pkg::cls_word_t           w;
  ctlp_pkg::fclass_t             cls_cur, cm_cls;
  ctlp_pkg::fin_req_t            req_r;
  logic                          take, fin_c, rec_c, clr;

  always_comb begin
    w       = head_i.word;
    take    = head_i.valid && room_i;
    len_inc = (len_r == 3'd7) ? 3'd7 : len_r + 3'd1;
    num10   = (num_r << 3) + (num_r << 1) + {60'd0, w.digit};
    sw10    = (sw_r << 3) + (sw_r << 1) + {60'd0, w.digit};
    idx_ext = {3'd0, idx_r};
    idx10   = (idx_ext << 3) + (idx_ext << 1) + {6'd0, w.digit};
    idx_sat = (idx10 > {3'd0, ctlp_pkg::MAX_CPUS_V}) ? ctlp_pkg::MAX_CPUS_V : idx10[6:0];
    lim     = (cpu_limit_i < ctlp_pkg::MAX_CPUS_V) ? cpu_limit_i : ctlp_pkg::MAX_CPUS_V;
    cls_cur = ctlp_pkg::field_class(fld_r);

    phase_tk = phase_r;
    fld_tk   = fld_r;
    num_tk   = num_r;
    idx_tk   = idx_r;
    busy_tk  = busy_r;
    idle_tk  = idle_r;
    guest_tk = guest_r;
    sw_tk    = sw_r;
    swf_tk   = swf_r;

    if (!w.is_nl) begin
      case (phase_r)
        PH_START: phase_tk = (w.text_byte == ctlp_pkg::CH_C) ? PH_C : PH_SKIP;
        PH_C: begin
          if (w.text_byte == ctlp_pkg::CH_P) phase_tk = PH_CP;
          else if (w.text_byte == ctlp_pkg::CH_T) phase_tk = PH_CT;
          else phase_tk = PH_SKIP;
        end
        PH_CP: phase_tk = (w.text_byte == ctlp_pkg::CH_U) ? PH_CPU : PH_SKIP;
        PH_CPU: begin
          if (w.is_digit) begin
            idx_tk   = {3'd0, w.digit};
            phase_tk = PH_INDEX;
          end else begin
            phase_tk = PH_SKIP;
          end
        end
        PH_INDEX: begin
          if (w.is_digit) idx_tk = idx_sat;
          else phase_tk = w.is_blank ? PH_FWS : PH_FROZEN;
        end
        PH_FWS: begin
          if (w.is_digit) begin
            num_tk   = {60'd0, w.digit};
            phase_tk = PH_FDIG;
          end else if (!w.is_blank) begin
            phase_tk = PH_FROZEN;
          end
        end
        PH_FDIG: begin
          if (w.is_digit) begin
            num_tk = num10;
          end else begin
            case (cls_cur)
              ctlp_pkg::FC_BUSY:  busy_tk  = busy_r + num_r;
              ctlp_pkg::FC_IDLE:  idle_tk  = idle_r + num_r;
              ctlp_pkg::FC_GUEST: guest_tk = guest_r + num_r;
              default: ;
            endcase
            num_tk   = '0;
            fld_tk   = fld_r + 4'd1;
            phase_tk = (w.is_blank && ((fld_r + 4'd1) < ctlp_pkg::NFIELDS_V)) ?
                       PH_FWS : PH_FROZEN;
          end
        end
        PH_CT:  phase_tk = (w.text_byte == ctlp_pkg::CH_X) ? PH_CTX : PH_SKIP;
        PH_CTX: phase_tk = (w.text_byte == ctlp_pkg::CH_T) ? PH_CTXT : PH_SKIP;
        PH_CTXT: begin
          if (w.text_byte == ctlp_pkg::CH_SP) begin
            sw_tk    = '0;
            swf_tk   = 1'b1;
            phase_tk = PH_SWWS;
          end else begin
            phase_tk = PH_SKIP;
          end
        end
        PH_SWWS: begin
          if (w.is_digit) begin
            sw_tk    = {60'd0, w.digit};
            phase_tk = PH_SWDIG;
          end else if (!w.is_blank) begin
            phase_tk = PH_SKIP;
          end
        end
        PH_SWDIG: begin
          if (w.is_digit) sw_tk = sw10;
          else phase_tk = PH_SKIP;
        end
        default: ;
      endcase
    end

    // a newline closes with the state as it stood; end of buffer after the byte
    fin_c   = in_cpu(phase_tk) && (w.is_nl || (w.eob && (len_inc >= 3'd5)));
    rec_c   = fin_c && (idx_tk < lim);
    idx_p1  = idx_tk + 7'd1;
    cnt_fin = (rec_c && (idx_p1 > cnt_r)) ? idx_p1 : cnt_r;
    cm_cls  = (phase_tk == PH_FDIG) ? ctlp_pkg::field_class(fld_tk) : ctlp_pkg::FC_NONE;

    clr = w.is_nl || w.eob;
    phase_nxt = clr ? PH_START : phase_tk;
    len_nxt   = clr ? 3'd0 : len_inc;
    fld_nxt   = clr ? '0 : fld_tk;
    num_nxt   = clr ? '0 : num_tk;
    idx_nxt   = clr ? '0 : idx_tk;
    busy_nxt  = clr ? '0 : busy_tk;
    idle_nxt  = clr ? '0 : idle_tk;
    guest_nxt = clr ? '0 : guest_tk;
    cnt_nxt   = w.eob ? '0 : cnt_fin;
    sw_nxt    = w.eob ? '0 : sw_tk;
    swf_nxt   = w.eob ? 1'b0 : swf_tk;
  end

  assign pop_o = take;
  assign req_o = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      len_r     <= '0;
      fld_r     <= '0;
      num_r     <= '0;
      idx_r     <= '0;
      busy_r    <= '0;
      idle_r    <= '0;
      guest_r   <= '0;
      cnt_r     <= '0;
      sw_r      <= '0;
      swf_r     <= 1'b0;
      req_r.rec <= 1'b0;
      req_r.sum <= 1'b0;
    end else begin
      req_r.rec <= take && rec_c;
      req_r.sum <= take && w.eob;
      if (take) begin
        phase_r      <= phase_nxt;
        len_r        <= len_nxt;
        fld_r        <= fld_nxt;
        num_r        <= num_nxt;
        idx_r        <= idx_nxt;
        busy_r       <= busy_nxt;
        idle_r       <= idle_nxt;
        guest_r      <= guest_nxt;
        cnt_r        <= cnt_nxt;
        sw_r         <= sw_nxt;
        swf_r        <= swf_nxt;
        req_r.idx    <= idx_tk[ctlp_pkg::CPU_W-1:0];
        req_r.busy   <= busy_tk;
        req_r.idle   <= idle_tk;
        req_r.guest  <= guest_tk;
        req_r.cm_num <= num_tk;
        req_r.cm_cls <= cm_cls;
        req_r.count  <= cnt_fin;
        req_r.sw     <= sw_tk;
        req_r.seen   <= swf_tk;
      end
    end
  end

  `CTLP_ASSERT_NOW(a_sum_clears, req_r.sum,
    (phase_r == PH_START) && (cnt_r == '0) && !swf_r && (len_r == 3'd0),
    "summary did not clear parser state")
  `CTLP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= ctlp_pkg::MAX_CPUS_V,
    "cpu count above maximum")
  `CTLP_ASSERT_NOW(a_rec_counted, req_r.rec && !req_r.sum,
    cnt_r > {1'b0, req_r.idx}, "record index not covered by cpu count")

endmodule

@@ hw/rtl/ctlp_emit.sv @@
// Result end: last field commit, guest subtraction and the output word queue.
`include "cpu_time_line_parser_top_macros.svh"

module ctlp_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctlp_pkg::fin_req_t   req_i,
  output logic                 room_o,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctlp_pkg::out_word_t  out_data
);

  ctlp_pkg::fin_sum_t  f_r;
  ctlp_pkg::out_word_t q_r [ctlp_pkg::OQ_DEPTH];
  logic [ctlp_pkg::OQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, sum_idx;
  logic [ctlp_pkg::OQ_AW:0]   occ_r, occ_nxt;
  logic [63:0] busy_c, idle_c, guest_c, busy_adj;
  logic [1:0]  npush, nreq;
  logic [4:0]  need;
  logic        pop;
  ctlp_pkg::out_word_t rec_word, sum_word;

  always_comb begin
    busy_c  = req_i.busy  + ((req_i.cm_cls == ctlp_pkg::FC_BUSY)  ? req_i.cm_num : 64'd0);
    idle_c  = req_i.idle  + ((req_i.cm_cls == ctlp_pkg::FC_IDLE)  ? req_i.cm_num : 64'd0);
    guest_c = req_i.guest + ((req_i.cm_cls == ctlp_pkg::FC_GUEST) ? req_i.cm_num : 64'd0);
  end

  always_comb begin
    busy_adj = (f_r.busy >= f_r.guest) ? f_r.busy - f_r.guest : f_r.busy;

    rec_word.record_kind  = ctlp_pkg::KIND_CPU;
    rec_word.cpu_number   = f_r.idx;
    rec_word.busy_ticks   = busy_adj;
    rec_word.idle_ticks   = f_r.idle;
    rec_word.cpu_total    = '0;
    rec_word.switch_total = '0;
    rec_word.switch_seen  = 1'b0;
    rec_word.final_result = !f_r.sum;

    sum_word.record_kind  = ctlp_pkg::KIND_SUM;
    sum_word.cpu_number   = '0;
    sum_word.busy_ticks   = '0;
    sum_word.idle_ticks   = '0;
    sum_word.cpu_total    = f_r.count;
    sum_word.switch_total = f_r.sw;
    sum_word.switch_seen  = f_r.seen;
    sum_word.final_result = 1'b1;

    npush   = {1'b0, f_r.rec} + {1'b0, f_r.sum};
    nreq    = {1'b0, req_i.rec} + {1'b0, req_i.sum};
    sum_idx = wp_r + ctlp_pkg::OQ_AW'(f_r.rec);
    pop     = out_valid && out_ready;
    wp_nxt  = wp_r + ctlp_pkg::OQ_AW'(npush);
    rp_nxt  = rp_r + ctlp_pkg::OQ_AW'(pop);
    occ_nxt = occ_r + (ctlp_pkg::OQ_AW+1)'(npush) - (ctlp_pkg::OQ_AW+1)'(pop);
    // everything in flight plus the worst case of the next word
    need    = 5'(occ_r) + 5'(npush) + 5'(nreq) + 5'd2;
  end

  assign room_o    = (need <= 5'(ctlp_pkg::OQ_DEPTH));
  assign out_valid = (occ_r != '0);
  assign out_data  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r.rec <= 1'b0;
      f_r.sum <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      occ_r   <= '0;
    end else begin
      f_r.rec <= req_i.rec;
      f_r.sum <= req_i.sum;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      occ_r   <= occ_nxt;
    end
    f_r.idx   <= req_i.idx;
    f_r.busy  <= busy_c;
    f_r.idle  <= idle_c;
    f_r.guest <= guest_c;
    f_r.count <= req_i.count;
    f_r.sw    <= req_i.sw;
    f_r.seen  <= req_i.seen;
  end

  always_ff @(posedge clk) begin
    if (f_r.rec) begin
      q_r[wp_r] <= rec_word;
    end
    if (f_r.sum) begin
      q_r[sum_idx] <= sum_word;
    end
  end

  `CTLP_ASSERT_NOW(a_sum_final,
    out_valid && (out_data.record_kind == ctlp_pkg::KIND_SUM),
    out_data.final_result, "summary word not marked final")
  `CTLP_ASSERT_NOW(a_no_overflow, f_r.rec || f_r.sum,
    (5'(occ_r) + 5'(npush)) <= 5'(ctlp_pkg::OQ_DEPTH), "output queue overflow")
  `CTLP_ASSERT_NEXT(a_rec_then_sum,
    pop && (out_data.record_kind == ctlp_pkg::KIND_CPU) && !out_data.final_result,
    out_valid && (out_data.record_kind == ctlp_pkg::KIND_SUM),
    "non-final record not followed by its summary")

endmodule

@@ hw/rtl/cpu_time_line_parser_top.sv @@
// Top level of the CPU time line parser. The block takes a statistics text
// buffer one byte per word and sustains one byte per clock unless the result
// queue lacks room: a small classify queue feeds the parser, and two pipeline
// stages (final field commit, then guest subtraction) feed an eight-word result
// queue. Records pass the request and commit registers into the result queue.
// The result port moves one word per cycle while out_ready is high, so a final
// byte that closes a cpu line yields two words (record, then summary); the
// parser stalls only when the result queue cannot hold everything already in
// flight. cpu_limit resets to 64; the user must write it only while no byte is
// in flight (the block does not enforce this); the value in force when a line
// ends decides whether its record is kept. No clearing pass follows reset.
module cpu_time_line_parser_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ctlp_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctlp_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ctlp_pkg::CNT_W-1:0]    cfg_data
);

  logic [ctlp_pkg::CNT_W-1:0] cpu_limit_r;
  ctlp_pkg::iq_head_t head;
  ctlp_pkg::fin_req_t req;
  logic pop;
  logic room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_limit_r <= ctlp_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cpu_limit_r <= cfg_data;
    end
  end

  ctlp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pop_i    (pop),
    .head_o   (head)
  );

  ctlp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cpu_limit_i (cpu_limit_r),
    .head_i      (head),
    .room_i      (room),
    .pop_o       (pop),
    .req_o       (req)
  );

  ctlp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (req),
    .room_o    (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/cpu_time_line_parser_top_tb.sv @@
// Self-checking testbench for the CPU time line parser top level.
`timescale 1ns / 100ps

module cpu_time_line_parser_top_tb;
  import ctlp_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_BYTES  = 240;

  // Field slots that do not count as busy time.
  localparam int FLD_IDLE       = 3;
  localparam int FLD_IOWAIT     = 4;
  localparam int FLD_GUEST      = 8;
  localparam int FLD_GUEST_NICE = 9;

  typedef enum logic [3:0] {
    ST_LINE_START, ST_C, ST_CP, ST_CPU, ST_INDEX, ST_FIELD_GAP, ST_FIELD_DIGIT,
    ST_FROZEN, ST_CT, ST_CTX, ST_CTXT, ST_SW_GAP, ST_SW_DIGIT, ST_SKIP
  } line_state_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  cpu_time_line_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Parser state mirror
  logic [CNT_W-1:0] limit_reg;
  line_state_t      pstate;
  int unsigned      line_len;
  int unsigned      field_idx;
  logic [63:0]      num_acc;
  int unsigned      idx_acc;
  logic [63:0]      busy_sum;
  logic [63:0]      idle_sum;
  logic [63:0]      guest_sum;
  int unsigned      cpus_seen;
  logic [63:0]      ctxt_value;
  logic             ctxt_found;

  out_word_t   step_words[$];
  out_word_t   expected_words[$];
  logic [7:0]  text_q[$];
  int          error_count = 0;
  int          bytes_sent = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;

  function automatic void reset_line();
    pstate    = ST_LINE_START;
    line_len  = 0;
    field_idx = 0;
    num_acc   = '0;
    idx_acc   = 0;
    busy_sum  = '0;
    idle_sum  = '0;
    guest_sum = '0;
  endfunction

  function automatic bit in_cpu_line();
    return pstate inside {ST_INDEX, ST_FIELD_GAP, ST_FIELD_DIGIT, ST_FROZEN};
  endfunction

  function automatic void fold_field();
    if (field_idx < NFIELDS) begin
      case (field_idx)
        FLD_IDLE, FLD_IOWAIT:      idle_sum  += num_acc;
        FLD_GUEST, FLD_GUEST_NICE: guest_sum += num_acc;
        default:                   busy_sum  += num_acc;
      endcase
    end
    num_acc = '0;
  endfunction

  function automatic void close_cpu_line();
    int unsigned lim;
    logic [63:0] busy;
    out_word_t   w;
    lim = (limit_reg < MAX_CPUS) ? limit_reg : MAX_CPUS;
    if (pstate == ST_FIELD_DIGIT) fold_field();
    if (idx_acc < lim) begin
      busy = busy_sum;
      if (busy >= guest_sum) busy -= guest_sum;
      w = '0;
      w.record_kind = KIND_CPU;
      w.cpu_number  = CPU_W'(idx_acc);
      w.busy_ticks  = busy;
      w.idle_ticks  = idle_sum;
      step_words.push_back(w);
      if (idx_acc + 1 > cpus_seen) cpus_seen = idx_acc + 1;
    end
  endfunction

  // Expected result words for one accepted text byte.
  function automatic void predict_byte(input logic [7:0] b, input logic eob);
    bit          dig;
    bit          blank;
    int unsigned v;
    out_word_t   w;
    dig   = (b >= CH_0) && (b <= CH_9);
    blank = (b == CH_SP) || (b == CH_TAB);
    if (line_len < 7) line_len++;
    if (b == CH_NL) begin
      if (in_cpu_line()) close_cpu_line();
      reset_line();
    end else begin
      // ASCII digits carry their value in the low nibble
      case (pstate)
        ST_LINE_START: pstate = (b == CH_C) ? ST_C : ST_SKIP;
        ST_C:          pstate = (b == CH_P) ? ST_CP : (b == CH_T) ? ST_CT : ST_SKIP;
        ST_CP:         pstate = (b == CH_U) ? ST_CPU : ST_SKIP;
        ST_CPU: begin
          if (dig) begin
            idx_acc = b[3:0];
            pstate  = ST_INDEX;
          end else begin
            pstate = ST_SKIP;
          end
        end
        ST_INDEX: begin
          if (dig) begin
            v       = idx_acc * 10 + b[3:0];
            idx_acc = (v > MAX_CPUS) ? MAX_CPUS : v;
          end else begin
            pstate = blank ? ST_FIELD_GAP : ST_FROZEN;
          end
        end
        ST_FIELD_GAP: begin
          if (dig) begin
            num_acc = 64'(b[3:0]);
            pstate  = ST_FIELD_DIGIT;
          end else if (!blank) begin
            pstate = ST_FROZEN;
          end
        end
        ST_FIELD_DIGIT: begin
          if (dig) begin
            num_acc = num_acc * 10 + 64'(b[3:0]);
          end else begin
            fold_field();
            field_idx++;
            pstate = (blank && field_idx < NFIELDS) ? ST_FIELD_GAP : ST_FROZEN;
          end
        end
        ST_CT:  pstate = (b == CH_X) ? ST_CTX : ST_SKIP;
        ST_CTX: pstate = (b == CH_T) ? ST_CTXT : ST_SKIP;
        ST_CTXT: begin
          if (b == CH_SP) begin
            ctxt_value = '0;
            ctxt_found = 1'b1;
            pstate     = ST_SW_GAP;
          end else begin
            pstate = ST_SKIP;
          end
        end
        ST_SW_GAP: begin
          if (dig) begin
            ctxt_value = 64'(b[3:0]);
            pstate     = ST_SW_DIGIT;
          end else if (!blank) begin
            pstate = ST_SKIP;
          end
        end
        ST_SW_DIGIT: begin
          if (dig) ctxt_value = ctxt_value * 10 + 64'(b[3:0]);
          else pstate = ST_SKIP;
        end
        default: ;
      endcase
    end
    if (eob) begin
      if (in_cpu_line() && line_len >= 5) close_cpu_line();
      w = '0;
      w.record_kind  = KIND_SUM;
      w.cpu_total    = CNT_W'(cpus_seen);
      w.switch_total = ctxt_value;
      w.switch_seen  = ctxt_found;
      step_words.push_back(w);
      reset_line();
      cpus_seen  = 0;
      ctxt_value = '0;
      ctxt_found = 1'b0;
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].final_result = 1'b1;
    while (step_words.size() > 0) expected_words.push_back(step_words.pop_front());
  endfunction

  function automatic string word_text(input out_word_t w);
    return $sformatf("kind %0d cpu %0d busy %h idle %h total %0d sw %h seen %0d last %0d",
                     w.record_kind, w.cpu_number, w.busy_ticks, w.idle_ticks,
                     w.cpu_total, w.switch_total, w.switch_seen, w.final_result);
  endfunction

  // Result side: random stalls and in-order compare.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected word: %s", word_text(out_data));
      end else begin
        want = expected_words.pop_front();
        if (out_data.record_kind  !== want.record_kind  ||
            out_data.cpu_number   !== want.cpu_number   ||
            out_data.busy_ticks   !== want.busy_ticks   ||
            out_data.idle_ticks   !== want.idle_ticks   ||
            out_data.cpu_total    !== want.cpu_total    ||
            out_data.switch_total !== want.switch_total ||
            out_data.switch_seen  !== want.switch_seen  ||
            out_data.final_result !== want.final_result) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: want %s", word_text(want));
            $display("          got  %s", word_text(out_data));
          end
        end
      end
    end
    out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    in_word_t w;
    // idle cycle by cycle so the sender is idle in about send_gap_pct of them
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.text_byte     = b;
    w.end_of_buffer = eob;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, eob);
    bytes_sent++;
  endtask

  task automatic send_text(input bit flag_last);
    foreach (text_q[i]) send_byte(text_q[i], flag_last && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  // Hold the sender until every expected word is out and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_blanks();
    repeat ($urandom_range(1, 2)) text_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endtask

  // Mostly short numbers, now and then long enough to wrap 64 bits.
  function automatic int num_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
  endfunction

  task automatic random_buffer();
    int lines;
    int kind;
    int pick;
    int nfld;
    lines = $urandom_range(1, 6);
    for (int l = 0; l < lines; l++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        put_str("cpu");
        pick = $urandom_range(0, 99);
        if (pick < 70) put_str($sformatf("%0d", $urandom_range(0, 9)));
        else if (pick < 90) put_str($sformatf("%0d", $urandom_range(10, 70)));
        else if (pick < 95) put_digits($urandom_range(3, 12));
        nfld = $urandom_range(0, 12);
        for (int f = 0; f < nfld; f++) begin
          put_blanks();
          put_digits(num_len());
          if ($urandom_range(0, 29) == 0) text_q.push_back(8'($urandom_range(0, 255)));
        end
      end else if (kind < 70) begin
        put_str("ct");
        if ($urandom_range(0, 9) != 0) put_str("xt");
        else text_q.push_back(8'($urandom_range(97, 122)));
        if ($urandom_range(0, 9) != 0) text_q.push_back(CH_SP);
        else text_q.push_back(CH_TAB);
        if ($urandom_range(0, 3) == 0) put_blanks();
        put_digits(num_len());
        if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(32, 126)));
      end else if (kind < 85) begin
        if ($urandom_range(0, 1)) put_str($urandom_range(0, 1) ? "cp" : "c");
        repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(32, 126)));
      end else begin
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      text_q.push_back(CH_NL);
    end
    // leave the last line unterminated now and then
    if (text_q.size() > 1 && $urandom_range(0, 2) == 0) void'(text_q.pop_back());
    send_text(1'b1);
  endtask

  task automatic test_plain_text();
    text_q.push_back(8'h00);
    text_q.push_back(8'hff);
    text_q.push_back(CH_NL);
    put_str("c");
    send_text(1'b1);
  endtask

  task automatic test_cpu_records();
    write_limit(LIMIT_RESET);
    put_str("cpu3 1 2 3 4 5 6 7 8 9 9\n");
    put_str("cpu1\t1 0 0 0 0 0 0 0 5\n");
    put_str("cpu0 99999999999999999999999\n");
    send_text(1'b1);
  endtask

  task automatic test_malformed_lines();
    put_str("cpu  5\ncpu2 7x 9\ncpu4 \ncpu5\ncpu99 1\ncpu64 1\ncpu63 1\n");
    send_text(1'b1);
  endtask

  task automatic test_switch_lines();
    put_str("ctxt 42\nctxt5\nctxt \n");
    send_text(1'b1);
    put_str("ctxt 7\nctxt  300");
    send_text(1'b1);
  endtask

  task automatic test_short_final_line();
    put_str("cpu1");
    send_text(1'b1);
    put_str("cpu1 ");
    send_text(1'b1);
    put_str("cpu12");
    send_text(1'b1);
  endtask

  task automatic test_limit_settings();
    write_limit('0);
    put_str("cpu0 1\n");
    send_text(1'b1);
    write_limit('1);
    put_str("cpu63 2\n");
    send_text(1'b1);
    write_limit(CNT_W'(1));
    put_str("cpu0 1\ncpu1 1\n");
    send_text(1'b1);
    // the limit in force at the line end decides
    put_str("cpu2 4");
    send_text(1'b0);
    write_limit(LIMIT_RESET);
    put_str("\n");
    send_text(1'b0);
    put_str("cpu5 1");
    send_text(1'b0);
    write_limit(CNT_W'(3));
    put_str("\n");
    send_text(1'b1);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall,
                                     input logic [CNT_W-1:0] lim);
    int start_count;
    write_limit(lim);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    start_count  = bytes_sent;
    while (bytes_sent - start_count < PHASE_BYTES) begin
      random_buffer();
      if ($urandom_range(0, 9) == 0) settle();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    limit_reg = LIMIT_RESET;
    reset_line();
    cpus_seen  = 0;
    ctxt_value = '0;
    ctxt_found = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_text();
    test_cpu_records();
    test_malformed_lines();
    test_switch_lines();
    test_short_final_line();
    test_limit_settings();
    test_random_traffic(0, 0, LIMIT_RESET);
    test_random_traffic(47, 0, CNT_W'(1));
    test_random_traffic(0, 47, '1);
    test_random_traffic(13, 13, CNT_W'(23));

    settle();
    if (error_count == 0) begin
      $display("[cpu_time_line_parser_top] OK");
    end else begin
      $display("[cpu_time_line_parser_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[cpu_time_line_parser_top] ERROR");
    $finish;
  end

endmodule
